FILE: rtl/core/assert_macros.svh
// Shared concurrent assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/robht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package robht_pkg;
	localparam int unsigned ORG_W  = 32;
	localparam int unsigned DIR_W  = 16;
	localparam int unsigned SIZE_W = 31;
	localparam int unsigned ROT_W  = 48;
	localparam int unsigned CIDX_W = 3;
	localparam int unsigned CDAT_W = 32;
	localparam int unsigned LAT    = 8;

	localparam int unsigned OFF_W = ORG_W + 1;       // origin minus center
	localparam int unsigned PD_W  = 2 * DIR_W;       // rot * dir
	localparam int unsigned PO_W  = DIR_W + OFF_W;   // rot * offset
	localparam int unsigned RD_W  = PD_W + 2;
	localparam int unsigned RO_W  = PO_W + 2;
	localparam int unsigned H_W   = SIZE_W + 13;
	localparam int unsigned A_W   = 32;
	localparam int unsigned N_W   = 52;
	localparam int unsigned NL_W  = 26;
	localparam int unsigned NH_W  = N_W - NL_W;
	localparam int unsigned PL_W  = NL_W + A_W;
	localparam int unsigned PH_W  = NH_W + A_W + 1;
	localparam int unsigned F_W   = N_W + A_W + 1;

	typedef enum logic [CIDX_W-1:0] {
		REG_ORG_X = 3'd0,
		REG_ORG_Y = 3'd1,
		REG_ORG_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5
	} cfg_reg_t;

	localparam logic [DIR_W-1:0] DIR_Z_RESET = 16'd16384;
endpackage
`default_nettype wire

FILE: rtl/core/ray_oriented_box_hit_test_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// box in    | start & !busy             | center_x/y/z, size_x/y/z, rot_row0/1/2
// result    | done (one-cycle strobe)   | hit
// config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// Eight-stage pipeline: one box per cycle, result strobed out of stage 8 after accept.
// The depth is set by the 52x32 cross-multiply compares, split into two 26-bit
// partial products and a recombine stage. busy stays low and cfg_ready high.
// arst_n clears valid bits and ray registers (direction resets to +z).
// The result side cannot stall, so the pipeline never holds.
module ray_oriented_box_hit_test_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [robht_pkg::ORG_W-1:0]  center_x,
	input  wire logic signed [robht_pkg::ORG_W-1:0]  center_y,
	input  wire logic signed [robht_pkg::ORG_W-1:0]  center_z,
	input  wire logic        [robht_pkg::SIZE_W-1:0] size_x,
	input  wire logic        [robht_pkg::SIZE_W-1:0] size_y,
	input  wire logic        [robht_pkg::SIZE_W-1:0] size_z,
	input  wire logic        [robht_pkg::ROT_W-1:0]  rot_row0,
	input  wire logic        [robht_pkg::ROT_W-1:0]  rot_row1,
	input  wire logic        [robht_pkg::ROT_W-1:0]  rot_row2,
	output logic                                     done,
	output logic                                     hit,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [robht_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic        [robht_pkg::CDAT_W-1:0] cfg_data
);
	import robht_pkg::*;
	`include "assert_macros.svh"

	logic signed [ORG_W-1:0] org_q [3];
	logic signed [DIR_W-1:0] dir_q [3];

	logic signed [DIR_W-1:0] rot_s1 [3][3];
	logic signed [DIR_W-1:0] dir_s1 [3];
	logic signed [OFF_W-1:0] off_s1 [3];
	logic        [H_W-1:0]   h_s1   [3];
	logic                    v_s1;

	logic signed [PD_W-1:0]  pd_s2 [3][3];
	logic signed [PO_W-1:0]  po_s2 [3][3];
	logic        [H_W-1:0]   h_s2  [3];
	logic                    v_s2;

	logic signed [RD_W-1:0]  rd_s3 [3];
	logic signed [RO_W-1:0]  ro_s3 [3];
	logic        [H_W-1:0]   h_s3  [3];
	logic                    v_s3;

	logic        [A_W-1:0]   a_s4   [3];
	logic signed [N_W-1:0]   en_s4  [3];
	logic signed [N_W-1:0]   ex_s4  [3];
	logic        [2:0]       lim_s4, hpos_s4, expos_s4;
	logic                    miss_s4, v_s4;

	logic        [PL_W-1:0]  pel_s5 [3][3];
	logic signed [PH_W-1:0]  peh_s5 [3][3];
	logic        [PL_W-1:0]  pxl_s5 [3][3];
	logic signed [PH_W-1:0]  pxh_s5 [3][3];
	logic        [2:0]       lim_s5, hpos_s5, expos_s5;
	logic                    miss_s5, v_s5;

	logic signed [F_W-1:0]   fe_s6 [3][3];
	logic signed [F_W-1:0]   fx_s6 [3][3];
	logic        [2:0]       lim_s6, hpos_s6, expos_s6;
	logic                    miss_s6, v_s6;

	logic        [2:0]       gten_s7 [3];
	logic        [2:0]       ltex_s7 [3];
	logic        [2:0]       cross_s7 [3];
	logic        [2:0]       lim_s7, expos_s7;
	logic                    miss_s7, v_s7;

	logic                    hit_s8, v_s8;

	logic [ROT_W-1:0]        rows [3];
	logic signed [ORG_W-1:0] ctr  [3];
	logic [SIZE_W-1:0]       sz   [3];
	logic [2:0]              ewin, xwin;
	logic [1:0]              esel, xsel;
	logic                    res;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = v_s8;
	assign hit       = hit_s8;

	assign rows = '{rot_row0, rot_row1, rot_row2};
	assign ctr  = '{center_x, center_y, center_z};
	assign sz   = '{size_x, size_y, size_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= DIR_Z_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORG_X: org_q[0] <= cfg_data;
				REG_ORG_Y: org_q[1] <= cfg_data;
				REG_ORG_Z: org_q[2] <= cfg_data;
				REG_DIR_X: dir_q[0] <= cfg_data[DIR_W-1:0];
				REG_DIR_Y: dir_q[1] <= cfg_data[DIR_W-1:0];
				REG_DIR_Z: dir_q[2] <= cfg_data[DIR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			hit_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			hit_s8 <= v_s7 && res;
		end
	end

	// datapath: payload registers, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			// stage 1: capture box, form origin offset and half extent
			for (int j = 0; j < 3; j++)
				rot_s1[i][j] <= rows[i][16*j +: 16];
			dir_s1[i] <= dir_q[i];
			off_s1[i] <= OFF_W'(org_q[i]) - OFF_W'(ctr[i]);
			h_s1[i]   <= {sz[i], 13'd0};

			// stage 2: rotate into box frame
			for (int j = 0; j < 3; j++) begin
				pd_s2[i][j] <= rot_s1[i][j] * dir_s1[j];
				po_s2[i][j] <= PO_W'(rot_s1[i][j]) * PO_W'(off_s1[j]);
			end
			h_s2[i] <= h_s1[i];

			// stage 3: row sums
			rd_s3[i] <= RD_W'(pd_s2[i][0]) + RD_W'(pd_s2[i][1]) + RD_W'(pd_s2[i][2]);
			ro_s3[i] <= RO_W'(po_s2[i][0]) + RO_W'(po_s2[i][1]) + RO_W'(po_s2[i][2]);
			h_s3[i]  <= h_s2[i];

			// stage 4: slab distances as fractions over a = |rd|
			a_s4[i]  <= rd_s3[i][RD_W-1] ? A_W'(-rd_s3[i]) : A_W'(rd_s3[i]);
			en_s4[i] <= (rd_s3[i] > 0 ? -N_W'(ro_s3[i]) : N_W'(ro_s3[i]))
				- $signed(N_W'(h_s3[i]));
			ex_s4[i] <= (rd_s3[i] > 0 ? -N_W'(ro_s3[i]) : N_W'(ro_s3[i]))
				+ $signed(N_W'(h_s3[i]));
			lim_s4[i]  <= (rd_s3[i] != '0);
			hpos_s4[i] <= (h_s3[i] != '0);

			// stage 5: split cross products into two partial products
			for (int k = 0; k < 3; k++) begin
				pel_s5[i][k] <= PL_W'(en_s4[i][NL_W-1:0]) * PL_W'(a_s4[k]);
				peh_s5[i][k] <= PH_W'($signed(en_s4[i][N_W-1:NL_W]))
					* $signed({1'b0, a_s4[k]});
				pxl_s5[i][k] <= PL_W'(ex_s4[i][NL_W-1:0]) * PL_W'(a_s4[k]);
				pxh_s5[i][k] <= PH_W'($signed(ex_s4[i][N_W-1:NL_W]))
					* $signed({1'b0, a_s4[k]});
			end
			expos_s5[i] <= expos_s4[i];

			// stage 6: recombine
			for (int k = 0; k < 3; k++) begin
				fe_s6[i][k] <= (F_W'(peh_s5[i][k]) <<< NL_W) + $signed(F_W'(pel_s5[i][k]));
				fx_s6[i][k] <= (F_W'(pxh_s5[i][k]) <<< NL_W) + $signed(F_W'(pxl_s5[i][k]));
			end
			expos_s6[i] <= expos_s5[i];

			// stage 7: pairwise fraction compares
			for (int k = 0; k < 3; k++) begin
				gten_s7[i][k]  <= fe_s6[i][k] > fe_s6[k][i];
				ltex_s7[i][k]  <= fx_s6[i][k] < fx_s6[k][i];
				cross_s7[i][k] <= (i == k) ? hpos_s6[i] : (fe_s6[i][k] < fx_s6[k][i]);
			end
			expos_s7[i] <= expos_s6[i];
		end
		for (int i = 0; i < 3; i++)
			expos_s4[i] <= (rd_s3[i] > 0 ? -N_W'(ro_s3[i]) : N_W'(ro_s3[i]))
				+ $signed(N_W'(h_s3[i])) > 0;
		miss_s4 <= ((rd_s3[0] == '0) && (ro_s3[0] < -$signed(RO_W'(h_s3[0]))
				|| ro_s3[0] > $signed(RO_W'(h_s3[0]))))
			|| ((rd_s3[1] == '0) && (ro_s3[1] < -$signed(RO_W'(h_s3[1]))
				|| ro_s3[1] > $signed(RO_W'(h_s3[1]))))
			|| ((rd_s3[2] == '0) && (ro_s3[2] < -$signed(RO_W'(h_s3[2]))
				|| ro_s3[2] > $signed(RO_W'(h_s3[2]))));
		lim_s5  <= lim_s4;
		hpos_s5 <= hpos_s4;
		miss_s5 <= miss_s4;
		lim_s6  <= lim_s5;
		hpos_s6 <= hpos_s5;
		miss_s6 <= miss_s5;
		lim_s7  <= lim_s6;
		miss_s7 <= miss_s6;
	end

	// stage 8: pick the latest entry and earliest exit, then decide
	always_comb begin
		ewin = lim_s7;
		xwin = lim_s7;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				if (k != i && lim_s7[k]) begin
					if (gten_s7[k][i])
						ewin[i] = 1'b0;
					if (ltex_s7[k][i])
						xwin[i] = 1'b0;
				end
		esel = ewin[0] ? 2'd0 : (ewin[1] ? 2'd1 : 2'd2);
		xsel = xwin[0] ? 2'd0 : (xwin[1] ? 2'd1 : 2'd2);
		if (miss_s7)
			res = 1'b0;
		else if (lim_s7 == '0)
			res = 1'b1;
		else
			res = expos_s7[xsel] && cross_s7[esel][xsel];
	end

	`ASSERT_IMPLIES(a_hit_strobed, clk, arst_n, hit, done, "hit without done")
	`ASSERT_IMPLIES(a_done_latency, clk, arst_n, done, $past(start, LAT),
		"result without a box accepted eight cycles before")
	`ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy && cfg_ready, "pipeline held off")
endmodule
`default_nettype wire

FILE: test/tb_ray_oriented_box_hit_test_core.sv
`timescale 1ns / 1ps
module tb_ray_oriented_box_hit_test_core;
	import robht_pkg::*;

	typedef struct {
		logic signed [ORG_W-1:0] cx, cy, cz;
		logic [SIZE_W-1:0]       sx, sy, sz;
		logic [ROT_W-1:0]        r0, r1, r2;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, hit, cfg_ready;
	logic signed [ORG_W-1:0] center_x = '0, center_y = '0, center_z = '0;
	logic [SIZE_W-1:0] size_x = '0, size_y = '0, size_z = '0;
	logic [ROT_W-1:0] rot_row0 = '0, rot_row1 = '0, rot_row2 = '0;
	logic cfg_valid = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CDAT_W-1:0] cfg_data = '0;

	ray_oriented_box_hit_test_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ray registers as the block should hold them
	logic signed [ORG_W-1:0] ray_org [3];
	logic signed [DIR_W-1:0] ray_dir [3];

	box_t pending_boxes[$];
	bit   expected_hits[$];
	box_t cur_box;
	int   fail_count = 0;
	int   hit_count = 0;
	int   result_count = 0;
	int   cycle_count = 0;
	bit   no_gaps = 1'b0;
	int   gap_left = 0;

	task automatic enqueue_box(box_t b);
		pending_boxes = {pending_boxes, b};
	endtask

	// sign of n1/a1 - n2/a2, denominators positive
	function automatic int frac_order(longint n1, longint a1, longint n2, longint a2);
		logic signed [127:0] w1, w2, d1, d2;
		w1 = n1; w2 = a2; d1 = n2; d2 = a1;
		w1 = w1 * w2;
		d1 = d1 * d2;
		if (w1 < d1) return -1;
		if (w1 > d1) return 1;
		return 0;
	endfunction

	function automatic bit box_hit(box_t b);
		longint rot [3][3];
		longint off [3];
		longint rd, ro, h, a, q, en, ex;
		longint near_n, near_a, far_n, far_a;
		logic [SIZE_W-1:0] sz [3];
		logic [ROT_W-1:0] rows [3];
		bit missed, limited;
		rows = '{b.r0, b.r1, b.r2};
		sz = '{b.sx, b.sy, b.sz};
		off[0] = longint'(ray_org[0]) - longint'(b.cx);
		off[1] = longint'(ray_org[1]) - longint'(b.cy);
		off[2] = longint'(ray_org[2]) - longint'(b.cz);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				rot[i][j] = longint'($signed(rows[i][16*j +: 16]));
		missed = 0; limited = 0;
		near_n = 0; near_a = 1; far_n = 0; far_a = 1;
		for (int i = 0; i < 3; i++) begin
			rd = 0; ro = 0;
			for (int j = 0; j < 3; j++) begin
				rd += rot[i][j] * longint'(ray_dir[j]);
				ro += rot[i][j] * off[j];
			end
			h = longint'(sz[i]) << 13;
			if (rd == 0) begin
				if (ro < -h || ro > h) missed = 1;
				continue;
			end
			if (rd > 0) begin
				a = rd; q = -ro;
			end else begin
				a = -rd; q = ro;
			end
			en = q - h;
			ex = q + h;
			if (!limited || frac_order(en, a, near_n, near_a) > 0) begin
				near_n = en; near_a = a;
			end
			if (!limited || frac_order(ex, a, far_n, far_a) < 0) begin
				far_n = ex; far_a = a;
			end
			limited = 1;
		end
		if (missed) return 0;
		if (!limited) return 1;
		return far_n > 0 && frac_order(near_n, near_a, far_n, far_a) < 0;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// box driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			bit accepted;
			accepted = start && !busy;
			if (accepted) begin
				expected_hits = {expected_hits, box_hit(cur_box)};
				void'(pending_boxes.pop_front());
				gap_left = pick_gap();
			end
			if (start && !accepted) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_boxes.size() > 0) begin
				cur_box = pending_boxes[0];
				center_x <= cur_box.cx; center_y <= cur_box.cy; center_z <= cur_box.cz;
				size_x <= cur_box.sx; size_y <= cur_box.sy; size_z <= cur_box.sz;
				rot_row0 <= cur_box.r0; rot_row1 <= cur_box.r1; rot_row2 <= cur_box.r2;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			result_count++;
			if (expected_hits.size() == 0) begin
				$error("unexpected result transaction: hit=%0b", hit);
				fail_count++;
			end else begin
				bit want;
				want = expected_hits.pop_front();
				if (want) hit_count++;
				if (hit !== want) begin
					$error("hit mismatch: expected %0b actual %0b", want, hit);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 300000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CDAT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_ORG_Z) ray_org[idx[1:0]] = value;
		else ray_dir[2'(idx - REG_DIR_X)] = value[DIR_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
		write_reg(REG_ORG_X, ox);
		write_reg(REG_ORG_Y, oy);
		write_reg(REG_ORG_Z, oz);
		write_reg(REG_DIR_X, {16'd0, dx});
		write_reg(REG_DIR_Y, {16'd0, dy});
		write_reg(REG_DIR_Z, {16'd0, dz});
	endtask

	task automatic drain();
		while (pending_boxes.size() != 0 || expected_hits.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic logic [ROT_W-1:0] pack_row(logic [15:0] c0, c1, c2);
		return {c2, c1, c0};
	endfunction

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'd16384;
			1: return -16'sd16384;
			2, 3: return 16'd0;
			4: return 16'($signed($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	// boxes placed near the ray so both hits and misses occur
	function automatic box_t near_box();
		box_t b;
		int p [3];
		int s [3];
		int k;
		p = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			k = $urandom_range(0, i);
			{p[i], p[k]} = {p[k], p[i]};
		end
		for (int i = 0; i < 3; i++) s[i] = $urandom_range(0, 1) ? 16384 : -16384;
		b.cx = ray_org[0] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		b.cy = ray_org[1] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		b.cz = ray_org[2] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		b.sx = 31'($urandom_range(0, 1 << 22));
		b.sy = 31'($urandom_range(0, 1 << 22));
		b.sz = 31'($urandom_range(0, 1 << 22));
		if ($urandom_range(0, 2) != 0) begin
			logic [15:0] m [3][3];
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m[i][j] = (p[i] == j) ? 16'(s[i]) : 16'd0;
			b.r0 = pack_row(m[0][0], m[0][1], m[0][2]);
			b.r1 = pack_row(m[1][0], m[1][1], m[1][2]);
			b.r2 = pack_row(m[2][0], m[2][1], m[2][2]);
		end else begin
			b.r0 = pack_row(rand_entry(), rand_entry(), rand_entry());
			b.r1 = pack_row(rand_entry(), rand_entry(), rand_entry());
			b.r2 = pack_row(rand_entry(), rand_entry(), rand_entry());
		end
		return b;
	endfunction

	function automatic box_t noise_box();
		box_t b;
		b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
		b.sx = 31'($urandom); b.sy = 31'($urandom); b.sz = 31'($urandom);
		b.r0 = 48'({$urandom, $urandom}); b.r1 = 48'({$urandom, $urandom});
		b.r2 = 48'({$urandom, $urandom});
		return b;
	endfunction

	function automatic box_t make_box(logic [31:0] cx, cy, cz, logic [30:0] sx, sy, sz,
			logic [47:0] r0, r1, r2);
		box_t b;
		b.cx = cx; b.cy = cy; b.cz = cz;
		b.sx = sx; b.sy = sy; b.sz = sz;
		b.r0 = r0; b.r1 = r1; b.r2 = r2;
		return b;
	endfunction

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++)
			enqueue_box($urandom_range(0, 4) == 0 ? noise_box() : near_box());
		drain();
	endtask

	initial begin
		logic [47:0] ident0, ident1, ident2;
		ray_org = '{0, 0, 0};
		ray_dir = '{16'sd0, 16'sd0, 16'sd16384};
		ident0 = pack_row(16'd16384, 16'd0, 16'd0);
		ident1 = pack_row(16'd0, 16'd16384, 16'd0);
		ident2 = pack_row(16'd0, 16'd0, 16'd16384);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ray: along +z from the origin
		enqueue_box(make_box(0, 0, 32'h0005_0000, 31'h2_0000, 31'h2_0000,
			31'h2_0000, ident0, ident1, ident2));
		enqueue_box(make_box(0, 0, -32'sh0005_0000, 31'h2_0000, 31'h2_0000,
			31'h2_0000, ident0, ident1, ident2));
		// origin exactly on the x face, x axis has no direction: boundary counts inside
		enqueue_box(make_box(-32'sh0001_0000, 0, 32'h0005_0000, 31'h2_0000,
			31'h2_0000, 31'h2_0000, ident0, ident1, ident2));
		enqueue_box(make_box(-32'sh0001_0001, 0, 32'h0005_0000, 31'h2_0000,
			31'h2_0000, 31'h2_0000, ident0, ident1, ident2));
		// zero rotation: every axis unlimited
		enqueue_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0,
			'0, '0, '0));
		enqueue_box(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, ident0, ident1, ident2));
		enqueue_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '1, '1, '1));
		enqueue_box(make_box(0, 0, 32'h0001_0000, 0, 0, 0,
			ident0, ident1, ident2));
		enqueue_box(make_box(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}));
		// box behind the origin only touching at the exit plane
		enqueue_box(make_box(0, 0, -32'sh0001_0000, 31'h2_0000, 31'h2_0000,
			31'h2_0000, ident0, ident1, ident2));
		drain();

		// extremes of origin and direction
		set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h8000);
		enqueue_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, {3{16'h8000}}, {3{16'h8000}},
			{3{16'h8000}}));
		enqueue_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			31'h1, 31'h1, 31'h1, ident0, ident1, ident2));
		enqueue_box(make_box(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}));
		random_phase(30);

		// all direction zero: hit only when the origin is inside
		set_ray(32'h0001_0000, 32'hFFFF_0000, 0, 16'd0, 16'd0, 16'd0);
		random_phase(50);

		for (int ph = 0; ph < 6; ph++) begin
			no_gaps = (ph % 3 == 1);
			set_ray($urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 20) - (1 << 19),
				$urandom_range(0, 1 << 20) - (1 << 19),
				$urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom),
				$urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom),
				$urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom));
			random_phase(70);
		end
		no_gaps = 1'b0;

		$display("Checked %0d box results (%0d hits) over several ray settings,", result_count,
			hit_count);
		$display("including extreme, zero and on-face cases.");
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
